// ===== rtl/core/qpd_pkg.sv =====
package qpd_pkg;

  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Depth of the output queue: room for the two words that one input word can
  // cause while one earlier word may still be waiting.
  localparam int unsigned QueueDepth = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } qpd_word_t;

  typedef struct packed {
    logic [1:0] num;
    logic [7:0] first;
    logic [7:0] second;
  } qpd_res_t;

  // Hex digit value: bit 4 set when the character is a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // Value of an escape '=' X Y, as a base-16 string parse of X Y, mod 256.
  function automatic logic [7:0] decode_pair(input logic [7:0] x, input logic [7:0] y);
    logic [4:0] hx;
    logic [4:0] hy;
    logic       ws;
    logic [7:0] r;
    hx = hex_val(x);
    hy = hex_val(y);
    ws = (x == CharSpace) || (x == CharTab) || (x == CharLf) || (x == CharVt) ||
         (x == CharFf) || (x == CharCr);
    r  = '0;
    if (hx[4]) begin
      r = hy[4] ? {hx[3:0], hy[3:0]} : {4'd0, hx[3:0]};
    end else if (hy[4]) begin
      if (ws || x == CharPlus) begin
        r = {4'd0, hy[3:0]};
      end else if (x == CharMinus) begin
        r = 8'd0 - {4'd0, hy[3:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/qpd_if.sv =====
interface qpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/core/qpd_escape.sv =====
module qpd_escape import qpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output qpd_res_t   res_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhEq   = 2'd1;
  localparam logic [1:0] PhHeld = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  qpd_res_t   res;

  always_comb begin
    phase_d = PhIdle;
    held_d  = held_q;
    res     = '0;
    case (phase_q)
      PhEq: begin
        if (byte_i == CharLf) begin
          res.num = 2'd0;
        end else if (last_i) begin
          res.num    = 2'd2;
          res.first  = CharEq;
          res.second = byte_i;
        end else begin
          held_d  = byte_i;
          phase_d = PhHeld;
        end
      end
      PhHeld: begin
        if (!(held_q == CharCr && byte_i == CharLf)) begin
          res.num   = 2'd1;
          res.first = decode_pair(held_q, byte_i);
        end
      end
      default: begin
        if (byte_i == CharEq) begin
          if (last_i) begin
            res.num   = 2'd1;
            res.first = CharEq;
          end else begin
            phase_d = PhEq;
          end
        end else begin
          res.num   = 2'd1;
          res.first = byte_i;
        end
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // An escape never survives the end of the input.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == PhIdle)
    else $error("escape pending after last word");

endmodule

// ===== rtl/core/quoted_printable_decoder.sv =====
// Channel  Dir  Payload             Handshake
// in_i     in   in_byte, in_last    valid/ready
// out_o    out  out_byte, run_last  valid/ready
//
// One input word is taken per cycle while the queue has room; its results are
// written into the output queue when it is taken. A word that causes two results
// (an '=' and the final byte) fills two queue entries, so the next input word waits.
// Input is accepted while at most one result waits in the queue.
// Reset clears the escape state and empties the queue.
module quoted_printable_decoder import qpd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  qpd_in_if.sink   in_i,
  qpd_out_if.source out_o
);

  qpd_word_t  queue_q [QueueDepth];
  qpd_word_t  queue_d [QueueDepth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       in_acc;
  logic       pop;
  qpd_res_t   res;

  assign in_i.ready = (cnt_q <= 2'd1);
  assign in_acc     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  qpd_escape u_escape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.in_last),
    .res_o    (res)
  );

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      queue_d[i] = queue_q[i];
    end
    if (pop) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        queue_d[i] = queue_q[i+1];
      end
    end
    base  = cnt_q - {1'b0, pop};
    cnt_d = base;
    if (in_acc) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (res.num != 2'd0 && 2'(i) == base) begin
          queue_d[i] = '{data: res.first, last: (res.num == 2'd1)};
        end
        if (res.num == 2'd2 && 2'(i) == base + 2'd1) begin
          queue_d[i] = '{data: res.second, last: 1'b1};
        end
      end
      cnt_d = base + res.num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = queue_q[0].data;
  assign out_o.run_last = queue_q[0].last;

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q <= 2'd1)
    else $error("word accepted without room for two results");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res.num == 2'd2 && !pop |=> cnt_q == $past(cnt_q) + 2'd2)
    else $error("result pair not queued");

  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res.num == 2'd2 && cnt_q == 2'd0 |=> !out_o.run_last)
    else $error("first of a result pair flagged as last");

endmodule

// ===== bench/tb_top.sv =====
module tb_top import qpd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 1150;
  localparam int unsigned StallLimit  = 400;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_EQ,
    ESC_HELD
  } esc_state_e;

  typedef struct {
    logic [7:0] code;
    logic       fin;
    logic       drain;
  } enc_word_t;

  logic clk_i;
  logic rst_ni;

  qpd_in_if  in_bus ();
  qpd_out_if out_bus ();

  quoted_printable_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  enc_word_t  enc_q[$];
  qpd_word_t  decoded_q[$];
  esc_state_e esc_state = ESC_NONE;
  logic [7:0] esc_held  = 8'h00;
  logic       drain_next = 1'b0;
  logic       in_taken   = 1'b0;
  logic       out_taken  = 1'b0;
  int         send_wait  = 0;
  int         send_run   = 0;
  int         recv_wait  = 0;
  int         recv_run   = 0;
  int         quiet_cycles = 0;
  int         err_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.in_byte  = 8'h00;
    in_bus.in_last  = 1'b0;
    out_bus.ready   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Value of a digit 0-9, a-f or A-F, or -1 for any other byte.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // The escape is read the way a base-16 string-to-integer parse would read it.
  function automatic logic [7:0] escape_value(input logic [7:0] x, input logic [7:0] y);
    int hx;
    int hy;
    hx = nibble_of(x);
    hy = nibble_of(y);
    if (hx >= 0) return (hy >= 0) ? 8'(hx * 16 + hy) : 8'(hx);
    if (hy < 0) return 8'h00;
    if (x inside {CharSpace, CharTab, CharLf, CharVt, CharFf, CharCr, CharPlus}) return 8'(hy);
    if (x == CharMinus) return 8'(256 - hy);
    return 8'h00;
  endfunction

  function automatic void expect_byte(input logic [7:0] d, input logic lst);
    qpd_word_t w;
    w.data = d;
    w.last = lst;
    decoded_q.push_back(w);
  endfunction

  function automatic void decode_word(input logic [7:0] b, input logic lst);
    case (esc_state)
      ESC_EQ: begin
        if (b == CharLf) begin
          esc_state = ESC_NONE;
        end else if (lst) begin
          // Escape cut short by the end of input: both bytes go out as they are.
          expect_byte(CharEq, 1'b0);
          expect_byte(b, 1'b1);
          esc_state = ESC_NONE;
        end else begin
          esc_held  = b;
          esc_state = ESC_HELD;
        end
      end
      ESC_HELD: begin
        esc_state = ESC_NONE;
        if (!(esc_held == CharCr && b == CharLf)) expect_byte(escape_value(esc_held, b), 1'b1);
      end
      default: begin
        esc_state = ESC_NONE;
        if (b == CharEq && !lst) begin
          esc_state = ESC_EQ;
        end else begin
          expect_byte(b, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic int pick_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void add(input logic [7:0] b, input logic lst);
    enc_word_t w;
    w.code  = b;
    w.fin   = lst;
    w.drain = drain_next;
    enc_q.push_back(w);
    drain_next = 1'b0;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(48 + v);
    if (v < 16) return 8'(87 + v);
    return 8'(49 + v);
  endfunction

  function automatic logic [7:0] odd_char();
    logic [7:0] ws[6];
    ws = '{CharSpace, CharTab, CharLf, CharVt, CharFf, CharCr};
    case ($urandom_range(0, 5))
      0: return hex_char();
      1: return ws[$urandom_range(0, 5)];
      2: return CharPlus;
      3: return CharMinus;
      4: return CharCr;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic rand_last();
    return ($urandom_range(0, 24) == 0);
  endfunction

  // Sender: a word is offered after its drawn gap and held until taken.
  always @(negedge clk_i) begin : drive_in
    enc_word_t  w;
    logic       nv;
    if (rst_ni && !(in_bus.valid && !in_taken)) begin
      nv = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
      end else if (enc_q.size() != 0 && !(enc_q[0].drain && decoded_q.size() != 0)) begin
        w = enc_q.pop_front();
        nv = 1'b1;
        in_bus.in_byte <= w.code;
        in_bus.in_last <= w.fin;
        send_wait = pick_wait(send_run);
      end
      in_bus.valid <= nv;
    end
  end

  // Receiver: after each word taken it may stall for a drawn number of cycles.
  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (out_taken) recv_wait = pick_wait(recv_run);
      if (recv_wait > 0) begin
        recv_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    qpd_word_t want;
    logic      in_fire;
    logic      out_fire;
    in_fire  = rst_ni && in_bus.valid && in_bus.ready;
    out_fire = rst_ni && out_bus.valid && out_bus.ready;
    in_taken  <= in_fire;
    out_taken <= out_fire;
    if (in_fire) decode_word(in_bus.in_byte, in_bus.in_last);
    if (out_fire) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected word: out_byte %02h, run_last %0b",
               out_bus.out_byte, out_bus.run_last);
        err_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_bus.out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_bus.out_byte);
          err_count++;
        end
        if (out_bus.run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, out_bus.run_last);
          err_count++;
        end
      end
    end
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("tb_top: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int target;
    // Plain bytes at both extremes, the second ending a stream.
    add(8'h00, 1'b0);
    add(8'hFF, 1'b1);
    // Hex digit followed by a non-hex byte.
    add(CharEq, 1'b0); add("f", 1'b0); add("Z", 1'b0);
    // Soft breaks, with and without the CR.
    add(CharEq, 1'b0); add(CharCr, 1'b0); add(CharLf, 1'b0);
    add(CharEq, 1'b0); add(CharLf, 1'b0);
    // Sign, leading whitespace and a pair that parses to nothing.
    add(CharEq, 1'b0); add(CharMinus, 1'b0); add("1", 1'b0);
    add(CharEq, 1'b0); add(CharTab, 1'b0); add("7", 1'b0);
    add(CharEq, 1'b0); add("z", 1'b0); add("z", 1'b0);
    // Escapes running into the end of input.
    add(CharEq, 1'b1);
    add(CharEq, 1'b0); add("Q", 1'b1);
    add(CharEq, 1'b0); add("a", 1'b0); add("9", 1'b1);
    add(CharEq, 1'b0); add(CharLf, 1'b1);

    target = enc_q.size() + RandomWords;
    drain_next = 1'b1;
    while (enc_q.size() < target) begin
      if ($urandom_range(0, 149) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add(8'($urandom_range(0, 255)), rand_last());
        4, 5, 6: begin
          add(CharEq, 1'b0);
          add(hex_char(), 1'b0);
          add(hex_char(), rand_last());
        end
        7: begin
          add(CharEq, 1'b0);
          if ($urandom_range(0, 1) == 1) add(CharCr, 1'b0);
          add(CharLf, rand_last());
        end
        8: begin
          add(CharEq, 1'b0);
          add(odd_char(), 1'b0);
          add(odd_char(), rand_last());
        end
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            add(CharEq, 1'b1);
          end else begin
            add(CharEq, 1'b0);
            add(odd_char(), 1'b1);
          end
        end
      endcase
    end

    while (enc_q.size() != 0 || in_bus.valid || decoded_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qpd_pkg.sv
rtl/core/qpd_if.sv
rtl/core/qpd_escape.sv
rtl/core/quoted_printable_decoder.sv
bench/tb_top.sv
